/* sv/ccm_pkg.sv */
// shared types, constants and aes helper functions for the ccm engine
package ccm_pkg;

    localparam int MIC_BYTES_DEF = 8;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_AAD   = 2'd1;
    localparam logic [1:0] FUNC_MSG   = 2'd2;
    localparam logic [1:0] FUNC_MIC   = 2'd3;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_MIC     = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    localparam logic [7:0] B0_FLAGS  = 8'h59;
    localparam logic [7:0] CTR_FLAGS = 8'h01;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_B0,
        ST_START_S0,
        ST_AAD,
        ST_AAD_ENC,
        ST_MSG,
        ST_MSG_KS,
        ST_MSG_MAC,
        ST_EMIT,
        ST_FINAL,
        ST_MIC_OUT,
        ST_MIC_RX,
        ST_VERDICT
    } ccm_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_start;
        logic start_b0;
        logic start_s0;
        logic aad_byte;
        logic msg_byte;
        logic enc_mac;
        logic enc_ks;
        logic finalize;
        logic mic_byte;
        logic clr_pos;
    } ccm_cmd_t;

    typedef struct packed {
        logic       aes_done;
        logic       aad_empty;
        logic       msg_empty;
        logic       pos_zero;
        logic       blk_full;
        logic       decrypt;
        logic [4:0] mic_count;
    } ccm_stat_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the 128-bit block sits at bits [127-8i -: 8]
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last_rnd);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, x;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[i+4*c] = b[i + 4*((c+i) % 4)];
        if (!last_rnd) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                x = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
        return r;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [7:0] next_rcon(input logic [7:0] rc);
        return xtime(rc);
    endfunction

endpackage

/* sv/ccm_aes_core.sv */
// iterative aes-128 encryption core, one round per cycle, round keys on the fly
module ccm_aes_core
    import ccm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [127:0] din,
    output logic         done,
    output logic [127:0] dout
);
    logic [127:0] state_reg, state_next;
    logic [127:0] rkey_reg, rkey_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        rkey_next  = rkey_reg;
        rcon_next  = rcon_reg;
        rnd_next   = rnd_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            state_next = din ^ key;
            rkey_next  = key_step(key, 8'h01);
            rcon_next  = next_rcon(8'h01);
            rnd_next   = 4'd1;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            state_next = aes_round(state_reg, rnd_reg == 4'd10) ^ rkey_reg;
            rkey_next  = key_step(rkey_reg, rcon_reg);
            rcon_next  = next_rcon(rcon_reg);
            rnd_next   = rnd_reg + 4'd1;
            if (rnd_reg == 4'd10) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            rnd_reg  <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        rkey_reg  <= rkey_next;
        rcon_reg  <= rcon_next;
    end

    assign done = done_reg;
    assign dout = state_reg;

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held");
    a_busy_rnd: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start) |-> (rnd_reg >= 4'd1 && rnd_reg <= 4'd10)) else $error("bad round");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("start while busy");
endmodule

/* sv/ccm_datapath.sv */
// ccm datapath: chain, keystream, mask, counters and output register
module ccm_datapath
    import ccm_pkg::*;
#(
    parameter int MIC_BYTES = MIC_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_sel,
    input  logic [63:0]  cfg_data,
    input  ccm_cmd_t     cmd,
    output ccm_stat_t    stat,
    input  logic         in_decrypt,
    input  logic [15:0]  in_aad_length,
    input  logic [15:0]  in_msg_length,
    input  logic [39:0]  in_nonce_high,
    input  logic [63:0]  in_nonce_low,
    input  logic [7:0]   in_data_byte,
    output logic [7:0]   pay_byte,
    output logic [7:0]   mic_out_byte,
    output logic         mic_match
);
    logic [127:0] key_reg;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] ks_reg, ks_next;
    logic [127:0] mask_reg, mask_next;
    logic [103:0] nonce_reg;
    logic [15:0]  ctr_reg, ctr_next;
    logic [4:0]   pos_reg, pos_next;
    logic [15:0]  aad_reg, aad_next;
    logic [15:0]  msg_reg, msg_next;
    logic         dec_reg;
    logic [7:0]   diff_reg, diff_next;
    logic [4:0]   mcnt_reg, mcnt_next;
    logic [7:0]   pay_reg, pay_next;
    logic         aes_start, aes_done;
    logic [127:0] aes_din, aes_dout;
    logic [3:0]   pidx;
    logic [7:0]   ks_b, plain_b, out_b, mask_b;
    logic [103:0] nonce_in;
    // destination of the running aes job
    logic stat_sel_ks_reg, stat_sel_mask_reg, stat_prefix_reg;

    assign nonce_in = {in_nonce_high, in_nonce_low};
    assign pidx   = pos_reg[3:0];
    assign ks_b   = ks_reg[127-8*pidx -: 8];
    assign out_b  = in_data_byte ^ ks_b;
    assign plain_b = dec_reg ? out_b : in_data_byte;
    assign mask_b = mask_reg[127-8*mcnt_reg[3:0] -: 8];

    assign aes_start = cmd.start_b0 | cmd.start_s0 | cmd.enc_mac | cmd.enc_ks;
    always_comb
    begin
        if (cmd.start_b0)
            aes_din = {B0_FLAGS, nonce_reg, msg_reg};
        else if (cmd.start_s0)
            aes_din = {CTR_FLAGS, nonce_reg, 16'h0000};
        else if (cmd.enc_ks)
            aes_din = {CTR_FLAGS, nonce_reg, ctr_reg};
        else
            aes_din = chain_reg;
    end

    ccm_aes_core u_aes (
        .clk   (clk),
        .rst_n (rst_n),
        .start (aes_start),
        .key   (key_reg),
        .din   (aes_din),
        .done  (aes_done),
        .dout  (aes_dout)
    );

    always_comb
    begin
        chain_next = chain_reg;
        ks_next    = ks_reg;
        mask_next  = mask_reg;
        ctr_next   = ctr_reg;
        pos_next   = pos_reg;
        aad_next   = aad_reg;
        msg_next   = msg_reg;
        diff_next  = diff_reg;
        mcnt_next  = mcnt_reg;
        pay_next   = pay_reg;
        if (cmd.load_start) begin
            aad_next = in_aad_length;
            msg_next = in_msg_length;
            ctr_next = 16'd1;
            pos_next = '0;
        end
        if (cmd.aad_byte) begin
            chain_next[127-8*pidx -: 8] = chain_reg[127-8*pidx -: 8] ^ in_data_byte;
            pos_next = pos_reg + 5'd1;
            aad_next = aad_reg - 16'd1;
        end
        if (cmd.msg_byte) begin
            chain_next[127-8*pidx -: 8] = chain_reg[127-8*pidx -: 8] ^ plain_b;
            pay_next = out_b;
            pos_next = pos_reg + 5'd1;
            msg_next = msg_reg - 16'd1;
        end
        if (cmd.clr_pos)
            pos_next = '0;
        if (cmd.enc_ks)
            ctr_next = ctr_reg + 16'd1;
        if (aes_done) begin
            if (stat_sel_ks_reg)
                ks_next = aes_dout;
            else if (stat_sel_mask_reg)
                mask_next = aes_dout;
            else begin
                chain_next = aes_dout;
                if (stat_prefix_reg) begin
                    chain_next[127:112] = aes_dout[127:112] ^ aad_reg;
                    if (aad_reg != 16'd0)
                        pos_next = 5'd2;
                end
            end
        end
        if (cmd.finalize) begin
            mask_next = mask_reg ^ chain_reg;
            mcnt_next = '0;
            diff_next = '0;
        end
        if (cmd.mic_byte) begin
            if (!mcnt_reg[4])
                diff_next = diff_reg | (in_data_byte ^ mask_b);
            mcnt_next = mcnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_reg           <= '0;
            chain_reg         <= '0;
            ks_reg            <= '0;
            mask_reg          <= '0;
            nonce_reg         <= '0;
            ctr_reg           <= 16'd1;
            pos_reg           <= '0;
            aad_reg           <= '0;
            msg_reg           <= '0;
            dec_reg           <= 1'b0;
            diff_reg          <= '0;
            mcnt_reg          <= '0;
            pay_reg           <= '0;
            stat_sel_ks_reg   <= 1'b0;
            stat_sel_mask_reg <= 1'b0;
            stat_prefix_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_sel == CFG_KEY_HIGH)
                    key_reg[127:64] <= cfg_data;
                else
                    key_reg[63:0] <= cfg_data;
            end
            if (cmd.load_start) begin
                nonce_reg <= nonce_in;
                dec_reg   <= in_decrypt;
            end
            chain_reg <= chain_next;
            ks_reg    <= ks_next;
            mask_reg  <= mask_next;
            ctr_reg   <= ctr_next;
            pos_reg   <= pos_next;
            aad_reg   <= aad_next;
            msg_reg   <= msg_next;
            diff_reg  <= diff_next;
            mcnt_reg  <= mcnt_next;
            pay_reg   <= pay_next;
            if (aes_start) begin
                stat_sel_ks_reg   <= cmd.enc_ks;
                stat_sel_mask_reg <= cmd.start_s0;
                stat_prefix_reg   <= cmd.start_b0;
            end
        end
    end

    assign stat.aes_done  = aes_done;
    assign stat.aad_empty = aad_reg == 16'd0;
    assign stat.msg_empty = msg_reg == 16'd0;
    assign stat.pos_zero  = pos_reg == 5'd0;
    assign stat.blk_full  = pos_reg[4];
    assign stat.decrypt   = dec_reg;
    assign stat.mic_count = mcnt_reg;

    assign pay_byte     = pay_reg;
    assign mic_out_byte = mask_b;
    assign mic_match    = diff_reg == 8'd0;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 5'd16) else $error("byte position overflow");
    a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.start_b0, cmd.start_s0, cmd.enc_mac, cmd.enc_ks}) <= 1)
        else $error("two aes jobs");
    a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.enc_ks && !cmd.load_start) |=> ctr_reg == $past(ctr_reg) + 16'd1)
        else $error("counter step");
endmodule

/* sv/ccm_ctrl.sv */
// ccm controller state machine: input/output handshakes and aes sequencing
module ccm_ctrl
    import ccm_pkg::*;
#(
    parameter int MIC_BYTES = MIC_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_func,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_kind,
    output logic       out_sel_mic,
    output logic       out_last,
    output ccm_cmd_t   cmd,
    input  ccm_stat_t  stat
);
    localparam logic [4:0] MIC_LAST = 5'(MIC_BYTES - 1);

    ccm_state_t state_reg, state_next;
    logic       acc;
    logic       fin_after_reg, fin_after_next;

    assign acc = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        fin_after_next = fin_after_reg;
        unique case (state_reg)
            ST_IDLE:
                if (acc && in_func == FUNC_START)
                    state_next = ST_START_B0;
            ST_START_B0:
                state_next = ST_START_S0;
            ST_START_S0:
                if (stat.aes_done)
                    state_next = ST_FINAL;
            ST_FINAL:
                // b0 done, s0 running; wait its end
                if (stat.aes_done) begin
                    if (!stat.aad_empty)
                        state_next = ST_AAD;
                    else if (!stat.msg_empty)
                        state_next = ST_MSG;
                    else
                        state_next = ST_MIC_OUT;
                end
            ST_AAD:
                if (acc && in_func == FUNC_AAD)
                    state_next = ST_AAD_ENC;
            ST_AAD_ENC:
                if (stat.aes_done || (!stat.blk_full &&
                    !(stat.aad_empty && !stat.pos_zero))) begin
                    if (!stat.aad_empty)
                        state_next = ST_AAD;
                    else if (!stat.msg_empty)
                        state_next = ST_MSG;
                    else
                        state_next = ST_MIC_OUT;
                end
            ST_MSG:
                if (acc && in_func == FUNC_MSG)
                    state_next = ST_MSG_MAC;
                else if (stat.pos_zero && !fin_after_reg)
                    state_next = ST_MSG_KS;
            ST_MSG_KS:
                if (stat.aes_done) begin
                    state_next     = ST_MSG;
                    fin_after_next = 1'b1;
                end
            ST_MSG_MAC:
                if (stat.aes_done || (!stat.blk_full && !stat.msg_empty)) begin
                    state_next = ST_EMIT;
                end
            ST_EMIT:
                if (out_ready) begin
                    if (stat.msg_empty)
                        state_next = ST_MIC_OUT;
                    else
                        state_next = ST_MSG;
                    if (stat.pos_zero)
                        fin_after_next = 1'b0;
                end
            ST_MIC_OUT:
                if (stat.decrypt)
                    state_next = ST_MIC_RX;
                else if (out_ready && stat.mic_count == MIC_LAST)
                    state_next = ST_IDLE;
            ST_MIC_RX:
                if (acc && in_func == FUNC_MIC && stat.mic_count == MIC_LAST)
                    state_next = ST_VERDICT;
            ST_VERDICT:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
        if (state_reg == ST_IDLE)
            fin_after_next = 1'b0;
    end

    // finalization step happens on the first cycle of ST_MIC_OUT
    logic fin_done_reg;

    always_comb
    begin
        cmd         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        out_kind    = KIND_DATA;
        out_sel_mic = 1'b0;
        out_last    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load_start = acc && in_func == FUNC_START;
            end
            ST_START_B0:
                cmd.start_b0 = 1'b1;
            ST_START_S0:
                cmd.start_s0 = stat.aes_done;
            ST_FINAL: ;
            ST_AAD:
            begin
                in_ready = 1'b1;
                cmd.aad_byte = acc && in_func == FUNC_AAD;
            end
            ST_AAD_ENC:
            begin
                if (stat.blk_full || (stat.aad_empty && !stat.pos_zero))
                    cmd.enc_mac = !stat.aes_done && !fin_done_reg;
                cmd.clr_pos = stat.aes_done ||
                              (stat.aad_empty && !stat.blk_full && stat.pos_zero);
            end
            ST_MSG:
            begin
                in_ready = !(stat.pos_zero && !fin_after_reg);
                cmd.msg_byte = acc && in_func == FUNC_MSG;
                cmd.enc_ks = stat.pos_zero && !fin_after_reg && !(acc && in_func == FUNC_MSG);
            end
            ST_MSG_KS: ;
            ST_MSG_MAC:
            begin
                if (stat.blk_full || stat.msg_empty)
                    cmd.enc_mac = !stat.aes_done && !fin_done_reg;
                cmd.clr_pos = stat.aes_done;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                out_kind  = KIND_DATA;
            end
            ST_MIC_OUT:
            begin
                cmd.finalize = !fin_done_reg;
                out_valid    = fin_done_reg && !stat.decrypt;
                out_kind     = KIND_MIC;
                out_sel_mic  = 1'b1;
                out_last     = stat.mic_count == MIC_LAST;
                cmd.mic_byte = out_valid && out_ready;
            end
            ST_MIC_RX:
            begin
                in_ready = 1'b1;
                cmd.mic_byte = acc && in_func == FUNC_MIC;
            end
            ST_VERDICT:
            begin
                out_valid = 1'b1;
                out_kind  = KIND_VERDICT;
                out_last  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            fin_after_reg <= 1'b0;
            fin_done_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fin_after_reg <= fin_after_next;
            // marks an aes job or the finalize step already issued in the current wait state
            if (state_next != state_reg)
                fin_done_reg <= 1'b0;
            else if (cmd.enc_mac || cmd.finalize)
                fin_done_reg <= 1'b1;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.aad_byte && cmd.msg_byte)) else $error("two byte commands");
    a_fin_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finalize |=> !cmd.finalize) else $error("finalize twice");
endmodule

/* sv/ccm_authenticated_cipher.sv */
// top level of the aes-128 ccm engine
// channel | direction | content
// s_axis  | in        | tuser func, tdata decrypt/aad_length/msg_length/nonce/data_byte
// m_axis  | out       | tuser kind, tdata out_byte/mic_ok, tlast last
// cfg     | in        | key_high (0), key_low (1)
// a start takes two aes runs (b0 and s0); each 16-byte message block takes two more,
// a keystream run and a cbc-mac run, on the single iterative aes core shared by ctr and cbc-mac
// each full aad block takes one cbc-mac aes run; each message byte also waits for its output to be taken
// reset clears all control and chain state; the key resets to zero
// a stalled result holds the block until it is taken
module ccm_authenticated_cipher
    import ccm_pkg::*;
#(
    parameter int MIC_BYTES = MIC_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [151:0] s_axis_tdata,  // decrypt, aad_length, msg_length, nonce_high, nonce_low, data_byte
    input  logic [1:0]   s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,  // out_byte, mic_ok
    output logic [1:0]   m_axis_tuser,  // kind
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data
);
    ccm_cmd_t  cmd;
    ccm_stat_t stat;
    logic [7:0] pay_byte, mic_byte;
    logic       mic_match, sel_mic;
    logic [1:0] kind;

    ccm_ctrl #(.MIC_BYTES(MIC_BYTES)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_func     (s_axis_tuser),
        .in_ready    (s_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_kind    (kind),
        .out_sel_mic (sel_mic),
        .out_last    (m_axis_tlast),
        .cmd         (cmd),
        .stat        (stat)
    );

    ccm_datapath #(.MIC_BYTES(MIC_BYTES)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_sel       (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat),
        .in_decrypt    (s_axis_tdata[0]),
        .in_aad_length (s_axis_tdata[16:1]),
        .in_msg_length (s_axis_tdata[32:17]),
        .in_nonce_high (s_axis_tdata[72:33]),
        .in_nonce_low  (s_axis_tdata[136:73]),
        .in_data_byte  (s_axis_tdata[144:137]),
        .pay_byte      (pay_byte),
        .mic_out_byte  (mic_byte),
        .mic_match     (mic_match)
    );

    assign m_axis_tuser = kind;
    always_comb
    begin
        m_axis_tdata = '0;
        case (kind)
            KIND_DATA:    m_axis_tdata[7:0] = pay_byte;
            KIND_MIC:     m_axis_tdata[7:0] = sel_mic ? mic_byte : 8'h00;
            KIND_VERDICT: m_axis_tdata[8]   = mic_match;
            default:      m_axis_tdata      = '0;
        endcase
    end
endmodule

/* dv/tb_ccm_authenticated_cipher.sv */
// self-checking testbench for the aes-128 ccm engine with its own bytewise predictor
`timescale 1ns / 1ps

module tb_ccm_authenticated_cipher;
    import ccm_pkg::*;

    localparam int MIC_LEN = MIC_BYTES_DEF;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef logic [7:0] blk_t [16];

    typedef struct {
        logic [1:0]  func;
        logic        dcr;
        logic [15:0] aad_len;
        logic [15:0] msg_len;
        logic [39:0] nonce_hi;
        logic [63:0] nonce_lo;
        logic [7:0]  data;
    } request_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] byte_val;
        logic       ok;
        logic       last;
    } result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_we;
    logic         cfg_index;
    logic [63:0]  cfg_data;

    ccm_authenticated_cipher u_dut (.*);

    request_t  pending_q [$];
    result_t   expected_q [$];
    int        fail_count;
    int        frame_count;
    int        result_count;
    int        request_count;
    longint    cycle_count;
    logic      stall_mode;
    logic      req_taken;
    int        hold_req;
    int        hold_seen;
    int        hold_left;
    logic [15:0] ready_pat;
    int        pat_idx;
    int        burst_left;
    int        gap_left;

    // predictor state
    logic [7:0]  sb [256];
    logic [63:0] key_hi, key_lo;
    logic [7:0]  rk [176];
    blk_t        chain, kstream, mask;
    logic [7:0]  nonce [13];
    logic [15:0] blk_ctr;
    int          pos;
    logic [15:0] aad_left, msg_left;
    int          phase_now;
    logic        dec_mode;
    logic [7:0]  mic_diff;
    int          mic_cnt;

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [7:0] gdbl(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = gdbl(a);
        end
        return p;
    endfunction

    task automatic build_sbox();
        logic [7:0] inv, r;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gmul(x[7:0], y[7:0]) == 8'h01)
                    inv = y[7:0];
            r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sb[x] = r;
        end
    endtask

    task automatic expand_keys();
        logic [7:0] t [4];
        logic [7:0] h;
        logic [7:0] rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
        begin
            rk[i]     = key_hi[63 - 8*i -: 8];
            rk[8 + i] = key_lo[63 - 8*i -: 8];
        end
        for (int i = 4; i < 44; i++)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = rk[(i - 1)*4 + j];
            if (i % 4 == 0)
            begin
                h = t[0];
                t[0] = sb[t[1]] ^ rc;
                t[1] = sb[t[2]];
                t[2] = sb[t[3]];
                t[3] = sb[h];
                rc = gdbl(rc);
            end
            for (int j = 0; j < 4; j++)
                rk[i*4 + j] = rk[(i - 4)*4 + j] ^ t[j];
        end
    endtask

    function automatic blk_t aes_block(blk_t s);
        blk_t t;
        logic [7:0] a0, a1, a2, a3, x;
        for (int i = 0; i < 16; i++)
            s[i] ^= rk[i];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[i + 4*c] = sb[s[i + 4*((c + i) % 4)]];
            if (r != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    x = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ x ^ gdbl(a0 ^ a1);
                    t[4*c+1] = a1 ^ x ^ gdbl(a1 ^ a2);
                    t[4*c+2] = a2 ^ x ^ gdbl(a2 ^ a3);
                    t[4*c+3] = a3 ^ x ^ gdbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ rk[r*16 + i];
        end
        return s;
    endfunction

    function automatic blk_t ctr_block(logic [15:0] ctr);
        blk_t b;
        b[0] = CTR_FLAGS;
        for (int i = 0; i < 13; i++)
            b[1 + i] = nonce[i];
        b[14] = ctr[15:8];
        b[15] = ctr[7:0];
        return b;
    endfunction

    task automatic push_result(logic [1:0] kind, logic [7:0] b, logic ok, logic last);
        result_t r;
        r.kind = kind;
        r.byte_val = b;
        r.ok = ok;
        r.last = last;
        expected_q.push_back(r);
    endtask

    task automatic close_tag();
        for (int i = 0; i < 16; i++)
            mask[i] ^= chain[i];
        if (dec_mode)
        begin
            phase_now = 3;
            mic_cnt = 0;
            mic_diff = 8'h00;
        end
        else
        begin
            for (int i = 0; i < MIC_LEN; i++)
                push_result(KIND_MIC, mask[i], 1'b0, i == MIC_LEN - 1);
            phase_now = 0;
        end
    endtask

    task automatic close_aad();
        if (pos != 0)
            chain = aes_block(chain);
        pos = 0;
        if (msg_left == 0)
            close_tag();
        else
            phase_now = 2;
    endtask

    task automatic ccm_predict(request_t q);
        logic [7:0] o, p;
        int k;
        case (q.func)
            FUNC_START:
            begin
                if (phase_now != 0)
                    return;
                dec_mode = q.dcr;
                aad_left = q.aad_len;
                msg_left = q.msg_len;
                for (int i = 0; i < 5; i++)
                    nonce[i] = q.nonce_hi[39 - 8*i -: 8];
                for (int i = 0; i < 8; i++)
                    nonce[5 + i] = q.nonce_lo[63 - 8*i -: 8];
                chain = ctr_block(msg_left);
                chain[0] = B0_FLAGS;
                chain = aes_block(chain);
                mask = aes_block(ctr_block(16'h0000));
                blk_ctr = 16'h0001;
                pos = 0;
                if (aad_left != 0)
                begin
                    chain[0] ^= aad_left[15:8];
                    chain[1] ^= aad_left[7:0];
                    pos = 2;
                    phase_now = 1;
                end
                else
                    close_aad();
            end
            FUNC_AAD:
            begin
                if (phase_now != 1)
                    return;
                chain[pos] ^= q.data;
                pos++;
                aad_left--;
                if (pos >= 16)
                begin
                    chain = aes_block(chain);
                    pos = 0;
                end
                if (aad_left == 0)
                    close_aad();
            end
            FUNC_MSG:
            begin
                if (phase_now != 2)
                    return;
                k = pos;
                if (k == 0)
                begin
                    kstream = aes_block(ctr_block(blk_ctr));
                    blk_ctr = blk_ctr + 16'd1;
                end
                o = q.data ^ kstream[k];
                p = dec_mode ? o : q.data;
                chain[k] ^= p;
                pos = k + 1;
                msg_left--;
                if (pos >= 16 || msg_left == 0)
                begin
                    chain = aes_block(chain);
                    pos = 0;
                end
                push_result(KIND_DATA, o, 1'b0, 1'b0);
                if (msg_left == 0)
                    close_tag();
            end
            default:
            begin
                if (phase_now != 3)
                    return;
                mic_diff |= q.data ^ mask[mic_cnt];
                mic_cnt++;
                if (mic_cnt >= MIC_LEN)
                begin
                    push_result(KIND_VERDICT, 8'h00, mic_diff == 8'h00, 1'b1);
                    phase_now = 0;
                end
            end
        endcase
    endtask

    // sender: bursts and gaps, request held until taken
    always @(negedge clk)
    begin
        request_t r;
        if (rst_n && (!s_axis_tvalid || req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                r = pending_q[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= r.func;
                s_axis_tdata <= {7'd0, r.data, r.nonce_lo, r.nonce_hi, r.msg_len, r.aad_len,
                                 r.dcr};
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // accepted requests feed the predictor
    always @(posedge clk)
    begin
        req_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (req_taken)
        begin
            ccm_predict(pending_q.pop_front());
            request_count++;
        end
    end

    // receiver: own stall pattern plus long hold-off on demand
    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= 600;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= stall_mode ? ready_pat[pat_idx] : 1'b1;
            pat_idx <= (pat_idx + 1) % 16;
        end
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result kind %0d byte %02h", m_axis_tuser, m_axis_tdata[7:0]);
                fail_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_axis_tuser !== e.kind)
                begin
                    $error("kind: expected %0d actual %0d", e.kind, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[7:0] !== e.byte_val)
                begin
                    $error("out_byte: expected %02h actual %02h", e.byte_val, m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tdata[8] !== e.ok)
                begin
                    $error("mic_ok: expected %0d actual %0d", e.ok, m_axis_tdata[8]);
                    fail_count++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("last: expected %0d actual %0d", e.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_req(logic [1:0] f, logic [7:0] d);
        request_t r;
        r.func = f;
        r.dcr = 1'($urandom_range(0, 1));
        r.aad_len = 16'($urandom);
        r.msg_len = 16'($urandom);
        r.nonce_hi = 40'({$urandom, $urandom});
        r.nonce_lo = {$urandom, $urandom};
        r.data = d;
        pending_q.push_back(r);
    endtask

    task automatic maybe_noise(logic [1:0] f);
        if ($urandom_range(0, 9) == 0)
            add_req(f, 8'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_key(logic idx, logic [63:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        if (idx == CFG_KEY_HIGH)
            key_hi = v;
        else
            key_lo = v;
        expand_keys();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_frame(logic dcr, logic [15:0] al, logic [15:0] ml, logic [39:0] nh,
                             logic [63:0] nl, logic bad_tag);
        request_t r;
        int which;
        r.func = FUNC_START;
        r.dcr = dcr;
        r.aad_len = al;
        r.msg_len = ml;
        r.nonce_hi = nh;
        r.nonce_lo = nl;
        r.data = 8'($urandom);
        maybe_noise(2'($urandom_range(1, 3)));
        pending_q.push_back(r);
        for (int i = 0; i < al; i++)
        begin
            if (i != 0)
                maybe_noise($urandom_range(0, 1) ? FUNC_START : FUNC_MIC);
            add_req(FUNC_AAD, 8'($urandom));
        end
        for (int i = 0; i < ml; i++)
        begin
            if (i != 0)
                maybe_noise($urandom_range(0, 1) ? FUNC_AAD : FUNC_MIC);
            add_req(FUNC_MSG, 8'($urandom));
        end
        if (dcr)
        begin
            wait_drained();
            which = $urandom_range(0, MIC_LEN - 1);
            for (int i = 0; i < MIC_LEN; i++)
            begin
                if (i != 0)
                    maybe_noise(FUNC_START);
                add_req(FUNC_MIC, mask[i] ^ ((bad_tag && i == which) ?
                        (8'h01 << $urandom_range(0, 7)) : 8'h00));
            end
        end
        frame_count++;
    endtask

    initial
    begin
        int n;
        logic dcr;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_START;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_KEY_HIGH;
        cfg_data = '0;
        fail_count = 0;
        frame_count = 0;
        result_count = 0;
        request_count = 0;
        cycle_count = 0;
        stall_mode = 1'b0;
        req_taken = 1'b0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        ready_pat = 16'hb6d3;
        pat_idx = 0;
        burst_left = 4;
        gap_left = 0;
        build_sbox();
        key_hi = '0;
        key_lo = '0;
        expand_keys();
        chain = '{default: 8'h00};
        kstream = '{default: 8'h00};
        mask = '{default: 8'h00};
        nonce = '{default: 8'h00};
        blk_ctr = 16'h0001;
        pos = 0;
        aad_left = '0;
        msg_left = '0;
        phase_now = 0;
        dec_mode = 1'b0;
        mic_diff = 8'h00;
        mic_cnt = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset key, empty parts, exact blocks, tag pass and fail
        add_req(FUNC_MIC, 8'hff);
        add_req(FUNC_MSG, 8'h00);
        run_frame(1'b0, 16'd0, 16'd0, '0, '0, 1'b0);
        run_frame(1'b1, 16'd0, 16'd0, '1, '1, 1'b0);
        run_frame(1'b0, 16'd14, 16'd16, '1, '0, 1'b0);
        wait_idle();
        write_key(CFG_KEY_HIGH, '1);
        write_key(CFG_KEY_LOW, '1);
        run_frame(1'b1, 16'd1, 16'd1, '0, '1, 1'b1);
        run_frame(1'b0, 16'd3, 16'd0, 40'({$urandom, $urandom}), {$urandom, $urandom}, 1'b0);
        wait_idle();

        // random frames, key changed between phases
        stall_mode = 1'b1;
        n = 0;
        while (n < 6)
        begin
            if (n % 4 == 0)
            begin
                wait_idle();
                write_key(1'($urandom_range(0, 1)), {$urandom, $urandom});
                ready_pat = 16'($urandom);
                stall_mode = $urandom_range(0, 3) != 0;
                if (n == 4)
                    hold_req++;
            end
            dcr = 1'($urandom_range(0, 1));
            run_frame(dcr, 16'($urandom_range(0, 20)), 16'($urandom_range(0, 24)),
                      40'({$urandom, $urandom}), {$urandom, $urandom},
                      $urandom_range(0, 2) == 0);
            n++;
        end

        wait_idle();
        repeat (100) @(posedge clk);
        $display("covered %0d frames, %0d requests taken, %0d results checked",
                 frame_count, request_count, result_count);
        $display("both directions, empty aad and message, key rewrites, long stalls");
        if (fail_count == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
